[src/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define LSQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define LSQ_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[src/lsq_pkg.sv]
// Package: shared types and constants of the largest square of ones unit
`default_nettype none

package lsq_pkg;

	localparam int unsigned DEF_MAX_COLS = 1024;
	localparam int unsigned DEF_MAX_ROWS = 1024;
	localparam int unsigned DIM_W        = 11;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

	typedef enum logic [0:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} lsq_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] best_side;
		logic [DIM_W-1:0] top_row;
		logic [DIM_W-1:0] left_col;
		logic             frame_done;
	} lsq_result_t;

endpackage

`default_nettype wire

[src/largest_square_of_ones_unit.sv]
// Top level: largest all-ones square over a raster stream of binary cells
//
// Cells enter on the req channel (req_valid / req_stall, payload cell_req) in
// raster order, num_cols per row and num_rows per frame, set through the write
// port (cfg_we, cfg_index, cfg_data). Each cell yields one item on the res
// channel: the best square side so far in the frame, its 1-based top-left
// corner, and frame_done on the frame's last cell; the frame then restarts.
// An accepted cell's item is registered in a result register, or, under a
// stall, in one skid entry; req_stall rises once both are occupied, so no
// item is lost. One cell per cycle is sustained while req_stall is low,
// set by the single line buffer read and write per cell. After reset the
// line buffer clears MAX_COLS entries with req_stall high; config writes
// are taken during that time. Both dimension registers reset to 1024.
`default_nettype none

module largest_square_of_ones_unit #(
	parameter int unsigned MAX_COLS = lsq_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS = lsq_pkg::DEF_MAX_ROWS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [lsq_pkg::DIM_W-1:0] cfg_data,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic                      cell_req,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic      [lsq_pkg::DIM_W-1:0] best_side,
	output logic      [lsq_pkg::DIM_W-1:0] top_row,
	output logic      [lsq_pkg::DIM_W-1:0] left_col,
	output logic                           frame_done
);

	localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned SIDE_W = $clog2(MAX_COLS + 1);

	logic [lsq_pkg::DIM_W-1:0] num_rows_q, num_cols_q;
	logic                      acc, busy, skid_full;
	logic [COL_W-1:0]          wr_addr, rd_addr;
	logic [SIDE_W-1:0]         wr_data, up_raw;
	lsq_pkg::lsq_result_t      core_res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= lsq_pkg::DIM_RESET;
			num_cols_q <= lsq_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (lsq_pkg::lsq_reg_t'(cfg_index))
				lsq_pkg::REG_NUM_ROWS: begin
					num_rows_q <= cfg_data;
				end
				lsq_pkg::REG_NUM_COLS: begin
					num_cols_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign req_stall = busy | skid_full;
	assign acc       = req_valid & ~req_stall;

	lsq_line_buf #(
		.MAX_COLS(MAX_COLS),
		.ADDR_W  (COL_W),
		.DATA_W  (SIDE_W)
	) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (acc),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(up_raw),
		.busy   (busy)
	);

	lsq_cell_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.COL_W   (COL_W),
		.ROW_W   (ROW_W),
		.SIDE_W  (SIDE_W)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.cell_bit(cell_req),
		.num_rows(num_rows_q),
		.num_cols(num_cols_q),
		.up_raw  (up_raw),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.res     (core_res)
	);

	lsq_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_res (core_res),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res      (out_res),
		.full     (skid_full)
	);

	assign best_side  = out_res.best_side;
	assign top_row    = out_res.top_row;
	assign left_col   = out_res.left_col;
	assign frame_done = out_res.frame_done;

endmodule

`default_nettype wire

[src/lsq_line_buf.sv]
// Line buffer: previous row's square sides, cleared once after reset
`default_nettype none

module lsq_line_buf #(
	parameter int unsigned MAX_COLS = lsq_pkg::DEF_MAX_COLS,
	parameter int unsigned ADDR_W   = 10,
	parameter int unsigned DATA_W   = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	output logic                   busy
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLS - 1);

	logic [DATA_W-1:0] mem [MAX_COLS];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              busy_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [DATA_W-1:0] wd;
	logic [DATA_W-1:0] rd_q;

	assign busy = busy_q;
	assign we   = busy_q | wr_en;
	assign wa   = busy_q ? clr_addr_q : wr_addr;
	assign wd   = busy_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		// forward a same-cycle write so a one-column row sees its own side
		if (we && (wa == rd_addr)) begin
			rd_q <= wd;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[src/lsq_cell_core.sv]
// Per-cell recurrence, raster counters and running best square
`default_nettype none

module lsq_cell_core #(
	parameter int unsigned MAX_COLS = lsq_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS = lsq_pkg::DEF_MAX_ROWS,
	parameter int unsigned COL_W    = 10,
	parameter int unsigned ROW_W    = 10,
	parameter int unsigned SIDE_W   = 11
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            acc,
	input  wire logic                            cell_bit,
	input  wire logic [lsq_pkg::DIM_W-1:0]       num_rows,
	input  wire logic [lsq_pkg::DIM_W-1:0]       num_cols,
	input  wire logic [SIDE_W-1:0]               up_raw,
	output logic      [COL_W-1:0]                wr_addr,
	output logic      [SIDE_W-1:0]               wr_data,
	output logic      [COL_W-1:0]                rd_addr,
	output lsq_pkg::lsq_result_t                 res
);

	localparam int unsigned DW  = lsq_pkg::DIM_W;
	localparam int unsigned CDW = (COL_W + 1 > DW) ? COL_W + 1 : DW;
	localparam int unsigned RDW = (ROW_W + 1 > DW) ? ROW_W + 1 : DW;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIDE_W-1:0] left_q, diag_q, best_size_q;
	logic [DW-1:0]     best_row_q, best_col_q;

	logic [CDW-1:0]    cols_eff;
	logic [RDW-1:0]    rows_eff;
	logic [SIDE_W-1:0] up, left, diag, m_ul, m_all, side;
	logic              row_end, frame_end, take;
	logic [SIDE_W-1:0] best_size_nxt;
	logic [DW-1:0]     best_row_nxt, best_col_nxt;

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (num_cols == '0) begin
			cols_eff = CDW'(1);
		end else if (CDW'(num_cols) > CDW'(MAX_COLS)) begin
			cols_eff = CDW'(MAX_COLS);
		end else begin
			cols_eff = CDW'(num_cols);
		end
		if (num_rows == '0) begin
			rows_eff = RDW'(1);
		end else if (RDW'(num_rows) > RDW'(MAX_ROWS)) begin
			rows_eff = RDW'(MAX_ROWS);
		end else begin
			rows_eff = RDW'(num_rows);
		end
	end

	always_comb begin
		up    = (row_q != '0) ? up_raw : '0;
		left  = (col_q != '0) ? left_q : '0;
		diag  = (row_q != '0 && col_q != '0) ? diag_q : '0;
		m_ul  = (up < left) ? up : left;
		m_all = (m_ul < diag) ? m_ul : diag;
		side  = cell_bit ? m_all + SIDE_W'(1) : '0;

		row_end   = (CDW'(col_q) + CDW'(1)) >= cols_eff;
		frame_end = row_end && ((RDW'(row_q) + RDW'(1)) >= rows_eff);

		// ties move the best too, so the last one in raster order wins
		take          = side >= best_size_q;
		best_size_nxt = take ? side : best_size_q;
		best_row_nxt  = take ? DW'(row_q) + DW'(2) - DW'(side) : best_row_q;
		best_col_nxt  = take ? DW'(col_q) + DW'(2) - DW'(side) : best_col_q;

		res.best_side  = DW'(best_size_nxt);
		res.top_row    = best_row_nxt;
		res.left_col   = best_col_nxt;
		res.frame_done = frame_end;

		wr_addr = col_q;
		wr_data = side;
		if (acc) begin
			rd_addr = row_end ? '0 : col_q + COL_W'(1);
		end else begin
			rd_addr = col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= DW'(1);
			best_col_q  <= DW'(1);
		end else if (acc) begin
			if (frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				left_q      <= '0;
				diag_q      <= '0;
				best_size_q <= '0;
				best_row_q  <= DW'(1);
				best_col_q  <= DW'(1);
			end else begin
				best_size_q <= best_size_nxt;
				best_row_q  <= best_row_nxt;
				best_col_q  <= best_col_nxt;
				if (row_end) begin
					col_q  <= '0;
					row_q  <= row_q + ROW_W'(1);
					left_q <= '0;
					diag_q <= '0;
				end else begin
					col_q  <= col_q + COL_W'(1);
					left_q <= side;
					diag_q <= up;
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/lsq_out_skid.sv]
// Result register with a skid entry so input keeps flowing under a stall
`default_nettype none

module lsq_out_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire lsq_pkg::lsq_result_t push_res,
	input  wire logic                 res_stall,
	output logic                      res_valid,
	output lsq_pkg::lsq_result_t      res,
	output logic                      full
);

	logic                 out_valid_q, skid_valid_q;
	lsq_pkg::lsq_result_t out_q, skid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= skid_valid_q && push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_res;
				end
			end else if (push) begin
				out_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

`default_nettype wire

[src/lsq_checker.sv]
// Port-level checker for the largest square of ones unit, bound to the top
`default_nettype none
`include "assert_macros.svh"

module lsq_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_stall,
	input wire logic                      res_valid,
	input wire logic                      res_stall,
	input wire logic [lsq_pkg::DIM_W-1:0] best_side,
	input wire logic [lsq_pkg::DIM_W-1:0] top_row,
	input wire logic [lsq_pkg::DIM_W-1:0] left_col,
	input wire logic                      frame_done
);

	logic [lsq_pkg::DIM_W-1:0] last_side_q;
	logic                      last_done_q;

	// side and end flag of the last item taken on the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_side_q <= '0;
			last_done_q <= 1'b1;
		end else if (res_valid && !res_stall) begin
			last_side_q <= best_side;
			last_done_q <= frame_done;
		end
	end

	`LSQ_ASSERT(a_res_hold, clk, arst_n, (res_valid && res_stall) |=> (res_valid && $stable(best_side) && $stable(top_row) && $stable(left_col) && $stable(frame_done)), "stalled item changed")
	`LSQ_ASSERT(a_best_monotonic, clk, arst_n, (res_valid && !last_done_q) |-> (best_side >= last_side_q), "best side shrank within a frame")
	`LSQ_ASSERT(a_one_cycle, clk, arst_n, (req_valid && !req_stall && !res_valid) |=> res_valid, "item into empty output not shown next cycle")

endmodule

bind largest_square_of_ones_unit lsq_checker u_lsq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.best_side (best_side),
	.top_row   (top_row),
	.left_col  (left_col),
	.frame_done(frame_done)
);

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the largest square of ones unit
`timescale 1ns / 1ps

module tb;

	localparam int unsigned MAX_COLS    = lsq_pkg::DEF_MAX_COLS;
	localparam int unsigned MAX_ROWS    = lsq_pkg::DEF_MAX_ROWS;
	localparam int unsigned DIM_W       = lsq_pkg::DIM_W;
	localparam int unsigned RAND_CELLS  = 550;
	localparam int unsigned CALM_CELLS  = 120;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned SHOW_LIMIT  = 40;

	typedef lsq_pkg::lsq_result_t lsq_result_t;

	typedef enum logic [1:0] {
		DIR_CELL,
		DIR_ROWS,
		DIR_COLS
	} dir_kind_t;

	typedef struct packed {
		dir_kind_t        kind;
		logic [DIM_W-1:0] val;
		bit               typed;
		lsq_result_t      fixed;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [0:0]       cfg_index = 1'b0;
	logic [DIM_W-1:0] cfg_data = '0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             cell_req = 1'b0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [DIM_W-1:0] best_side;
	logic [DIM_W-1:0] top_row;
	logic [DIM_W-1:0] left_col;
	logic             frame_done;

	largest_square_of_ones_unit #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cell_req  (cell_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.best_side (best_side),
		.top_row   (top_row),
		.left_col  (left_col),
		.frame_done(frame_done)
	);

	// predictor state
	int unsigned      above_row [MAX_COLS];
	int unsigned      run_left, run_diag, col_idx, row_idx;
	int unsigned      top_side, top_r, top_c;
	logic [DIM_W-1:0] cfg_rows = lsq_pkg::DIM_RESET;
	logic [DIM_W-1:0] cfg_cols = lsq_pkg::DIM_RESET;

	lsq_result_t best_queue [$];

	int  err_count, results_seen, frames_seen, cells_sent, dim_writes;
	int  widest_side;
	bit  idle_on, hold_go;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout: %0d results still pending", best_queue.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	// side of the square ending at this cell, then the running best of the frame
	function automatic lsq_result_t square_step(logic cell_bit);
		int unsigned nrows, ncols, col, up, lf, dg, side;
		bit          row_last, frame_last;
		lsq_result_t r;
		nrows = fit_dim(cfg_rows, MAX_ROWS);
		ncols = fit_dim(cfg_cols, MAX_COLS);
		col = col_idx % MAX_COLS;
		up = (row_idx > 0) ? above_row[col] : 0;
		lf = (col_idx > 0) ? run_left : 0;
		dg = (row_idx > 0 && col_idx > 0) ? run_diag : 0;
		side = 0;
		if (cell_bit) begin
			side = (up < lf) ? up : lf;
			if (dg < side)
				side = dg;
			side++;
		end
		row_last = (col_idx + 1 >= ncols);
		frame_last = row_last && (row_idx + 1 >= nrows);
		run_diag = up;
		run_left = side;
		above_row[col] = side;
		// ties move the corner too, so the last one in raster order wins
		if (side >= top_side) begin
			top_side = side;
			top_r = row_idx + 2 - side;
			top_c = col_idx + 2 - side;
		end
		r.best_side = DIM_W'(top_side);
		r.top_row = DIM_W'(top_r);
		r.left_col = DIM_W'(top_c);
		r.frame_done = frame_last;
		if (frame_last) begin
			run_left = 0;
			run_diag = 0;
			col_idx = 0;
			row_idx = 0;
			top_side = 0;
			top_r = 1;
			top_c = 1;
		end else if (row_last) begin
			col_idx = 0;
			row_idx++;
			run_left = 0;
			run_diag = 0;
		end else begin
			col_idx++;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (err_count < SHOW_LIMIT)
			$display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [DIM_W-1:0] got,
			input logic [DIM_W-1:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	always @(posedge clk) begin : result_monitor
		lsq_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (best_queue.size() == 0) begin
				flag_mismatch("result with no cell pending");
			end else begin
				want = best_queue.pop_front();
				check_field("best_side", best_side, want.best_side);
				check_field("top_row", top_row, want.top_row);
				check_field("left_col", left_col, want.left_col);
				check_field("frame_done", DIM_W'(frame_done), DIM_W'(want.frame_done));
			end
			if (frame_done === 1'b1)
				frames_seen++;
			if (best_side > widest_side)
				widest_side = best_side;
			results_seen++;
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin : receiver
		int burst, hold;
		burst = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				res_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 14) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_cell(input logic v, input bit typed = 1'b0,
			input lsq_result_t fixed = '0);
		int          gap;
		lsq_result_t want;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cell_req <= v;
		do @(posedge clk); while (req_stall);
		want = square_step(v);
		if (typed)
			want = fixed;
		best_queue = {best_queue, want};
		cells_sent++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (best_queue.size() != 0) @(posedge clk);
	endtask

	// cfg_we drops and the task waits an idle edge so back-to-back writes never share a time step
	task automatic write_dim(input lsq_pkg::lsq_reg_t idx, input logic [DIM_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lsq_pkg::REG_NUM_ROWS)
			cfg_rows = val;
		else
			cfg_cols = val;
		dim_writes++;
		@(posedge clk);
	endtask

	// a 1x1 setting ends whatever frame is open on the next cell
	task automatic align_frame();
		if (col_idx != 0 || row_idx != 0) begin
			write_dim(lsq_pkg::REG_NUM_ROWS, '0);
			write_dim(lsq_pkg::REG_NUM_COLS, '0);
			send_cell($urandom_range(0, 1));
		end
	endtask

	task automatic send_run(input int n, input int dens, input bit zeros);
		repeat (n) send_cell(zeros ? 1'b0 : ($urandom_range(0, 99) < dens));
	endtask

	function automatic lsq_result_t res(int b, int r, int c, bit d);
		res.best_side = DIM_W'(b);
		res.top_row = DIM_W'(r);
		res.left_col = DIM_W'(c);
		res.frame_done = d;
	endfunction

	function automatic dir_row_t cell_row(bit v);
		return '{kind: DIR_CELL, val: DIM_W'(v), typed: 1'b0, fixed: '0};
	endfunction

	function automatic dir_row_t cell_row_exp(bit v, lsq_result_t r);
		return '{kind: DIR_CELL, val: DIM_W'(v), typed: 1'b1, fixed: r};
	endfunction

	function automatic dir_row_t dim_row(dir_kind_t k, int v);
		return '{kind: k, val: DIM_W'(v), typed: 1'b0, fixed: '0};
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_W'($urandom_range(41, 2047));
			2, 3: return DIM_W'($urandom_range(9, 40));
			default: return DIM_W'($urandom_range(1, 8));
		endcase
	endfunction

	dir_row_t dir_tab [29];

	initial begin : stimulus
		int unsigned rand_cells, area, n, dens;
		foreach (above_row[i]) above_row[i] = 0;
		run_left = 0;
		run_diag = 0;
		col_idx = 0;
		row_idx = 0;
		top_side = 0;
		top_r = 1;
		top_c = 1;
		idle_on = 1'b1;
		hold_go = 1'b0;
		rand_cells = 0;

		// default 1024x1024 after reset, then 1x1 frames, a full 3x3, a 2x4
		dir_tab = '{
			cell_row_exp(1'b0, res(0, 2, 2, 1'b0)),
			cell_row_exp(1'b1, res(1, 1, 2, 1'b0)),
			cell_row_exp(1'b1, res(1, 1, 3, 1'b0)),
			dim_row(DIR_ROWS, 0),
			dim_row(DIR_COLS, 0),
			cell_row(1'b0),
			cell_row_exp(1'b1, res(1, 1, 1, 1'b1)),
			cell_row_exp(1'b0, res(0, 2, 2, 1'b1)),
			dim_row(DIR_ROWS, 3),
			dim_row(DIR_COLS, 3),
			cell_row(1'b1), cell_row(1'b1), cell_row(1'b1), cell_row(1'b1),
			cell_row(1'b1), cell_row(1'b1), cell_row(1'b1), cell_row(1'b1),
			cell_row_exp(1'b1, res(3, 1, 1, 1'b1)),
			dim_row(DIR_ROWS, 2),
			dim_row(DIR_COLS, 4),
			cell_row(1'b1), cell_row(1'b1), cell_row(1'b0), cell_row(1'b1),
			cell_row(1'b1), cell_row(1'b1), cell_row(1'b1), cell_row(1'b1)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				DIR_ROWS: write_dim(lsq_pkg::REG_NUM_ROWS, dir_tab[i].val);
				DIR_COLS: write_dim(lsq_pkg::REG_NUM_COLS, dir_tab[i].val);
				default: send_cell(dir_tab[i].val[0], dir_tab[i].typed, dir_tab[i].fixed);
			endcase
		end

		// output held off while cells keep coming, so the input must stall
		align_frame();
		write_dim(lsq_pkg::REG_NUM_ROWS, 11'd4);
		write_dim(lsq_pkg::REG_NUM_COLS, 11'd4);
		hold_go = 1'b1;
		send_run(32, 70, 1'b0);

		// out-of-range sizes: 2047 clamps to the maximum, 0 acts as one
		align_frame();
		write_dim(lsq_pkg::REG_NUM_ROWS, 11'd1);
		write_dim(lsq_pkg::REG_NUM_COLS, 11'd2047);
		send_run(40, 0, 1'b1);
		write_dim(lsq_pkg::REG_NUM_ROWS, 11'd2047);
		write_dim(lsq_pkg::REG_NUM_COLS, 11'd0);
		send_run(40, 0, 1'b1);

		while (rand_cells < RAND_CELLS) begin
			if (rand_cells + CALM_CELLS < RAND_CELLS)
				idle_on = ($urandom_range(0, 4) != 0);
			else
				idle_on = 1'b0;
			if ($urandom_range(0, 9) < 7)
				align_frame();
			write_dim(lsq_pkg::REG_NUM_ROWS, pick_dim());
			write_dim(lsq_pkg::REG_NUM_COLS, pick_dim());
			case ($urandom_range(0, 3))
				0: dens = 25;
				1: dens = 50;
				2: dens = 80;
				default: dens = 95;
			endcase
			area = fit_dim(cfg_rows, MAX_ROWS) * fit_dim(cfg_cols, MAX_COLS);
			if (area <= 64) begin
				n = area * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, area);
			end else begin
				n = $urandom_range(20, 60);
			end
			send_run(n, dens, 1'b0);
			rand_cells += n;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Ran %0d cells, %0d size writes; %0d frames closed, widest side %0d.",
			cells_sent, dim_writes, frames_seen, widest_side);
		$display("Covered 1x1 frames, sizes 0 and 2047, mid-frame resizes, a %0d-cycle hold.",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/lsq_pkg.sv
src/lsq_line_buf.sv
src/lsq_cell_core.sv
src/lsq_out_skid.sv
src/largest_square_of_ones_unit.sv
src/lsq_checker.sv
bench/tb.sv
